>>> rtl/bdq_pkg.sv
// Shared types and constants for the bounded deque with value removal.
// Request formats, result codes and the controller/datapath interface.
// No dependencies.
`timescale 1ns / 1ps

package bdq_pkg;

  // Store depth; a power of two so that circular indexing is a plain wrap.
  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  // Operation kinds
  localparam logic [2:0] KIND_PUSH_FRONT  = 3'd0;
  localparam logic [2:0] KIND_PUSH_BACK   = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT   = 3'd2;
  localparam logic [2:0] KIND_POP_BACK    = 3'd3;
  localparam logic [2:0] KIND_EXISTS      = 3'd4;
  localparam logic [2:0] KIND_REMOVE_FIRST = 3'd5;
  localparam logic [2:0] KIND_REMOVE_ALL  = 3'd6;
  localparam logic [2:0] KIND_CLEAR       = 3'd7;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
  } op_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [6:0]         entry_count;
    logic [6:0]         removed_count;
  } res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start;      // request accepted: latch it, apply push/pop/clear
    logic scan;       // one step of the search / compaction pass
    logic finish;     // close the pass, settle counts and status
    logic rd_front;   // read address = front slot
    logic rd_back;    // read address = back slot
    logic cap_front;  // capture front word from read data
    logic cap_back;   // capture back word, zero both if empty
    logic load_out;   // move result into the output register
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_req;   // incoming request needs a pass over the store
    logic scan_done;  // pass has read and handled every entry
  } dp_stat_t;

endpackage

>>> rtl/bdq_datapath.sv
// Datapath for the bounded deque: entry memory, head/occupancy, scan
// counters, result fields and output payload register. Uses bdq_pkg.
`timescale 1ns / 1ps

module bdq_datapath (
  input  logic            clk,
  input  logic            rst_n,
  input  bdq_pkg::op_t    in_data,
  input  bdq_pkg::ctl_cmd_t cmd,
  output bdq_pkg::dp_stat_t stat,
  output bdq_pkg::res_t   out_data
);

  logic [31:0] mem [bdq_pkg::DEPTH];

  logic [bdq_pkg::AW-1:0] head_r, head_nxt;
  logic [bdq_pkg::CW-1:0] occ_r, occ_nxt;
  logic [bdq_pkg::CW-1:0] rd_cnt_r, rd_cnt_nxt;
  logic [bdq_pkg::CW-1:0] wr_cnt_r, wr_cnt_nxt;
  logic [bdq_pkg::CW-1:0] gone_r, gone_nxt;
  logic                   dv_r, dv_nxt;
  logic [2:0]             kind_r, kind_nxt;
  logic [31:0]            value_r, value_nxt;
  logic [1:0]             status_r, status_nxt;
  logic                   found_r, found_nxt;
  logic [bdq_pkg::CW-1:0] removed_r, removed_nxt;
  logic [31:0]            front_r, front_nxt;
  logic [31:0]            back_r, back_nxt;
  logic [31:0]            rdata_r;
  bdq_pkg::res_t          out_r, out_nxt;

  logic                   we;
  logic [bdq_pkg::AW-1:0] waddr;
  logic [31:0]            wdata;
  logic [bdq_pkg::AW-1:0] rd_addr;
  logic                   match;
  logic                   is_search;
  logic [bdq_pkg::CW-1:0] occ_m1;

  assign is_search = (in_data.kind == bdq_pkg::KIND_EXISTS)
                  || (in_data.kind == bdq_pkg::KIND_REMOVE_FIRST)
                  || (in_data.kind == bdq_pkg::KIND_REMOVE_ALL);
  assign occ_m1    = occ_r - 1'b1;

  assign stat.scan_req  = is_search && (occ_r != '0);
  assign stat.scan_done = (rd_cnt_r == occ_r) && !dv_r;

  assign match = (rdata_r == value_r)
              && !((kind_r == bdq_pkg::KIND_REMOVE_FIRST) && (gone_r != '0));

  always_comb begin
    head_nxt    = head_r;
    occ_nxt     = occ_r;
    rd_cnt_nxt  = rd_cnt_r;
    wr_cnt_nxt  = wr_cnt_r;
    gone_nxt    = gone_r;
    dv_nxt      = dv_r;
    kind_nxt    = kind_r;
    value_nxt   = value_r;
    status_nxt  = status_r;
    found_nxt   = found_r;
    removed_nxt = removed_r;
    front_nxt   = front_r;
    back_nxt    = back_r;
    out_nxt     = out_r;
    we          = 1'b0;
    waddr       = head_r;
    wdata       = in_data.value;
    rd_addr     = head_r;

    if (cmd.start) begin
      kind_nxt    = in_data.kind;
      value_nxt   = in_data.value;
      status_nxt  = bdq_pkg::ST_OK;
      found_nxt   = 1'b0;
      removed_nxt = '0;
      rd_cnt_nxt  = '0;
      wr_cnt_nxt  = '0;
      gone_nxt    = '0;
      dv_nxt      = 1'b0;
      unique case (in_data.kind)
        bdq_pkg::KIND_PUSH_FRONT: begin
          if (occ_r == bdq_pkg::CW'(bdq_pkg::DEPTH)) begin
            status_nxt = bdq_pkg::ST_FULL;
          end else begin
            head_nxt = head_r - 1'b1;
            we       = 1'b1;
            waddr    = head_r - 1'b1;
            occ_nxt  = occ_r + 1'b1;
          end
        end
        bdq_pkg::KIND_PUSH_BACK: begin
          if (occ_r == bdq_pkg::CW'(bdq_pkg::DEPTH)) begin
            status_nxt = bdq_pkg::ST_FULL;
          end else begin
            we      = 1'b1;
            waddr   = head_r + occ_r[bdq_pkg::AW-1:0];
            occ_nxt = occ_r + 1'b1;
          end
        end
        bdq_pkg::KIND_POP_FRONT, bdq_pkg::KIND_POP_BACK: begin
          if (occ_r == '0) begin
            status_nxt = bdq_pkg::ST_EMPTY;
          end else begin
            if (in_data.kind == bdq_pkg::KIND_POP_FRONT) begin
              head_nxt = head_r + 1'b1;
            end
            occ_nxt     = occ_m1;
            removed_nxt = bdq_pkg::CW'(1);
          end
        end
        bdq_pkg::KIND_EXISTS, bdq_pkg::KIND_REMOVE_FIRST, bdq_pkg::KIND_REMOVE_ALL: begin
          if (occ_r == '0) begin
            status_nxt = bdq_pkg::ST_EMPTY;
          end
        end
        default: begin
          removed_nxt = occ_r;
          occ_nxt     = '0;
          head_nxt    = '0;
        end
      endcase
    end

    if (cmd.scan) begin
      // read side runs one entry ahead of the compare/write side
      if (rd_cnt_r < occ_r) begin
        rd_addr    = head_r + rd_cnt_r[bdq_pkg::AW-1:0];
        rd_cnt_nxt = rd_cnt_r + 1'b1;
        dv_nxt     = 1'b1;
      end else begin
        dv_nxt = 1'b0;
      end
      if (dv_r) begin
        if (match) begin
          gone_nxt = gone_r + 1'b1;
        end else begin
          we         = (kind_r != bdq_pkg::KIND_EXISTS);
          waddr      = head_r + wr_cnt_r[bdq_pkg::AW-1:0];
          wdata      = rdata_r;
          wr_cnt_nxt = wr_cnt_r + 1'b1;
        end
      end
    end

    if (cmd.finish) begin
      found_nxt  = (gone_r != '0);
      status_nxt = (gone_r != '0) ? bdq_pkg::ST_OK : bdq_pkg::ST_NOT_FOUND;
      if ((kind_r != bdq_pkg::KIND_EXISTS) && (gone_r != '0)) begin
        occ_nxt     = wr_cnt_r;
        removed_nxt = gone_r;
      end
    end

    if (cmd.rd_front) begin
      rd_addr = head_r;
    end
    if (cmd.rd_back) begin
      rd_addr = head_r + occ_m1[bdq_pkg::AW-1:0];
    end
    if (cmd.cap_front) begin
      front_nxt = rdata_r;
    end
    if (cmd.cap_back) begin
      if (occ_r == '0) begin
        front_nxt = '0;
        back_nxt  = '0;
      end else begin
        back_nxt = rdata_r;
      end
    end

    if (cmd.load_out) begin
      out_nxt.status        = status_r;
      out_nxt.found         = found_r;
      out_nxt.front_value   = front_r;
      out_nxt.back_value    = back_r;
      out_nxt.entry_count   = 7'(occ_r);
      out_nxt.removed_count = 7'(removed_r);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      occ_r  <= '0;
      dv_r   <= 1'b0;
    end else begin
      head_r <= head_nxt;
      occ_r  <= occ_nxt;
      dv_r   <= dv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_cnt_r  <= rd_cnt_nxt;
    wr_cnt_r  <= wr_cnt_nxt;
    gone_r    <= gone_nxt;
    kind_r    <= kind_nxt;
    value_r   <= value_nxt;
    status_r  <= status_nxt;
    found_r   <= found_nxt;
    removed_r <= removed_nxt;
    front_r   <= front_nxt;
    back_r    <= back_nxt;
    out_r     <= out_nxt;
  end

  assign out_data = out_r;

endmodule

>>> rtl/bdq_ctrl.sv
// Controller state machine for the bounded deque: input handshake,
// sequencing of scan and end-read steps, output valid. Uses bdq_pkg.
`timescale 1ns / 1ps

module bdq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  bdq_pkg::dp_stat_t   stat,
  output bdq_pkg::ctl_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_RDF  = 3'd2;
  localparam logic [2:0] S_RDB  = 3'd3;
  localparam logic [2:0] S_CAPB = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = stat.scan_req ? S_SCAN : S_RDF;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          cmd.finish = 1'b1;
          state_nxt  = S_RDF;
        end
      end
      S_RDF: begin
        cmd.rd_front = 1'b1;
        state_nxt    = S_RDB;
      end
      S_RDB: begin
        cmd.rd_back   = 1'b1;
        cmd.cap_front = 1'b1;
        state_nxt     = S_CAPB;
      end
      S_CAPB: begin
        cmd.cap_back = 1'b1;
        state_nxt    = S_WAIT;
      end
      S_WAIT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.load_out | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/bounded_deque_with_value_removal.sv
// Top level of the bounded deque with value removal.
// Joins bdq_ctrl and bdq_datapath; types from bdq_pkg.
`timescale 1ns / 1ps

// Usage
//  - Input channel (in_valid / in_stall / in_data): one request per operation,
//    kind plus a 32-bit word. Taken when in_valid is high and in_stall low.
//  - Result channel (out_valid / out_stall / out_data): exactly one result
//    per request, in request order, held steady while out_stall is high.
//  - Push, pop and clear: the accept edge applies the change, then the front
//    and back words are read through the single read port of the store (two
//    reads, registered data) and the result is loaded.
//  - Exists / remove first / remove all: one pass over the held entries, on
//    top of the above. The pass reads one entry a cycle and, for the remove
//    kinds, writes kept entries back in place, so the read port of the
//    entry store sets the rate.
//  - For push/pop/clear the result reaches out_data after the read-front,
//    read-back and capture-back states. One request in flight at a time.
//  - A result waiting on out_stall does not hold the input: the next
//    request is taken and worked; it only waits at the very end for the
//    output register to free up.
//  - Reset (rst_n low, synchronous) empties the deque and drops any result
//    in flight. Store contents are not cleared; only held entries are read.

module bounded_deque_with_value_removal (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bdq_pkg::op_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output bdq_pkg::res_t out_data
);

  bdq_pkg::ctl_cmd_t cmd;
  bdq_pkg::dp_stat_t stat;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  bdq_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
